// ===== hdl/velocity_frame_rotation_macros.svh =====
`ifndef VELOCITY_FRAME_ROTATION_MACROS_SVH
`define VELOCITY_FRAME_ROTATION_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define VFR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("velocity_frame_rotation: assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define VFR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("velocity_frame_rotation: assertion failed");

`endif

// ===== hdl/vfr_pkg.sv =====
package vfr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GAIN_SHIFT = 30;
  localparam int TABLE_LEN  = 24;
  localparam int ANGLE_BITS = 16;
  localparam int Z_BITS     = 32;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

  localparam logic signed [Z_BITS-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

// ===== hdl/vfr_prescale.sv =====
module vfr_prescale #(
  parameter int SB = 16,
  parameter int W  = 35
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [1:0]                            en,
  input  logic                                  in_vld,
  input  logic signed [vfr_pkg::ANGLE_BITS-1:0] angle,
  input  logic signed [SB-1:0]                  vx,
  input  logic signed [SB-1:0]                  vy,
  output logic [1:0]                            vld,
  output logic signed [W-1:0]                   x,
  output logic signed [W-1:0]                   y,
  output logic signed [vfr_pkg::Z_BITS-1:0]     z
);
  import vfr_pkg::*;

  localparam int PW = SB + 33;
  localparam int LO = GAIN_SHIFT - FRAC_BITS;

  logic                          flip;
  logic signed [SB:0]            vx_ext;
  logic signed [SB:0]            vy_ext;
  logic signed [SB:0]            nx;
  logic signed [SB:0]            ny;
  logic signed [ANGLE_BITS-1:0]  ang;
  logic signed [PW-1:0]          px;
  logic signed [PW-1:0]          py;

  // fold angles outside a quarter turn: negate the vector, remove a half turn
  assign flip   = angle[ANGLE_BITS-1] ^ angle[ANGLE_BITS-2];
  assign vx_ext = {vx[SB-1], vx};
  assign vy_ext = {vy[SB-1], vy};

  assign px = nx * GAIN_Q30;
  assign py = ny * GAIN_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_vld;
      if (en[1]) vld[1] <= vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      nx  <= flip ? -vx_ext : vx_ext;
      ny  <= flip ? -vy_ext : vy_ext;
      ang <= {angle[ANGLE_BITS-1] ^ flip, angle[ANGLE_BITS-2:0]};
    end
    if (en[1]) begin
      x <= px[W+LO-1:LO];
      y <= py[W+LO-1:LO];
      z <= {ang, {(Z_BITS-ANGLE_BITS){1'b0}}};
    end
  end

endmodule

// ===== hdl/vfr_cell.sv =====
module vfr_cell #(
  parameter int W    = 35,
  parameter int STEP = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [W-1:0]               x_in,
  input  logic signed [W-1:0]               y_in,
  input  logic signed [vfr_pkg::Z_BITS-1:0] z_in,
  output logic                              vld,
  output logic signed [W-1:0]               x,
  output logic signed [W-1:0]               y,
  output logic signed [vfr_pkg::Z_BITS-1:0] z
);
  import vfr_pkg::*;

  logic signed [W-1:0]      dx;
  logic signed [W-1:0]      dy;
  logic signed [W-1:0]      x_next;
  logic signed [W-1:0]      y_next;
  logic signed [Z_BITS-1:0] z_next;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_comb begin
    if (!z_in[Z_BITS-1]) begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ATAN_TURNS[STEP];
    end else begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ATAN_TURNS[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

// ===== hdl/vfr_finish.sv =====
module vfr_finish #(
  parameter int SB = 16,
  parameter int W  = 35
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output logic                vld,
  output logic [SB-1:0]       bx,
  output logic [SB-1:0]       by,
  output logic                sat
);
  import vfr_pkg::*;

  localparam int RW = W - FRAC_BITS;
  localparam logic signed [W-1:0] HALF =
    {{(W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  logic signed [W-1:0]  xr;
  logic signed [W-1:0]  yr;
  logic [RW-SB:0]       xt;
  logic [RW-SB:0]       yt;
  logic                 x_ovf;
  logic                 y_ovf;
  logic [SB-1:0]        x_sat;
  logic [SB-1:0]        y_sat;

  assign xr = x_in + HALF;
  assign yr = y_in + HALF;
  assign xt = xr[W-1:FRAC_BITS+SB-1];
  assign yt = yr[W-1:FRAC_BITS+SB-1];
  assign x_ovf = !((&xt) || !(|xt));
  assign y_ovf = !((&yt) || !(|yt));

  always_comb begin
    if (x_ovf) begin
      x_sat = xr[W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      x_sat = xr[FRAC_BITS+SB-1:FRAC_BITS];
    end
    if (y_ovf) begin
      y_sat = yr[W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      y_sat = yr[FRAC_BITS+SB-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx  <= x_sat;
      by  <= y_sat;
      sat <= x_ovf || y_ovf;
    end
  end

endmodule

// ===== hdl/velocity_frame_rotation.sv =====
// Stages: fold, gain multiply, one cell per microrotation (at most TABLE_LEN), round
//   and saturate into the output register.
// Throughput: one request per cycle, stalled only when every stage is full and out_ready
//   is low; each stage holds one request and advances whenever it or some stage after it is empty.
// Reset: clears the valid bit of every stage; data registers are not reset.
module velocity_frame_rotation #(
  parameter int MICRO_ROTATIONS = 16,
  parameter int SPEED_BITS      = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [vfr_pkg::ANGLE_BITS-1:0] heading_angle,
  input  logic signed [SPEED_BITS-1:0]          world_x_speed,
  input  logic signed [SPEED_BITS-1:0]          world_y_speed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SPEED_BITS-1:0]          body_x_speed,
  output logic signed [SPEED_BITS-1:0]          body_y_speed,
  output logic                                  clipped
);
  import vfr_pkg::*;

  `include "velocity_frame_rotation_macros.svh"

  localparam int W = SPEED_BITS + FRAC_BITS + 3;
  localparam int C = (MICRO_ROTATIONS < TABLE_LEN) ? MICRO_ROTATIONS : TABLE_LEN;
  localparam int N = C + 3;

  logic [N-1:0]             vld;
  logic [N-1:0]             en;
  logic signed [W-1:0]      cx [C+1];
  logic signed [W-1:0]      cy [C+1];
  logic signed [Z_BITS-1:0] cz [C+1];
  logic [SPEED_BITS-1:0]    bx;
  logic [SPEED_BITS-1:0]    by;

  // advance a stage when it is empty or the stage after it advances
  assign en[N-1] = !vld[N-1] || out_ready;
  genvar k;
  generate
    for (k = 0; k < N-1; k++) begin : g_en
      assign en[k] = !vld[k] || en[k+1];
    end
  endgenerate

  assign in_ready = en[0];

  vfr_prescale #(
    .SB (SPEED_BITS),
    .W  (W)
  ) u_prescale (
    .clk    (clk),
    .rst    (rst),
    .en     (en[1:0]),
    .in_vld (in_valid),
    .angle  (heading_angle),
    .vx     (world_x_speed),
    .vy     (world_y_speed),
    .vld    (vld[1:0]),
    .x      (cx[0]),
    .y      (cy[0]),
    .z      (cz[0])
  );

  generate
    for (k = 0; k < C; k++) begin : g_cell
      vfr_cell #(
        .W    (W),
        .STEP (k)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .en     (en[k+2]),
        .in_vld (vld[k+1]),
        .x_in   (cx[k]),
        .y_in   (cy[k]),
        .z_in   (cz[k]),
        .vld    (vld[k+2]),
        .x      (cx[k+1]),
        .y      (cy[k+1]),
        .z      (cz[k+1])
      );
    end
  endgenerate

  vfr_finish #(
    .SB (SPEED_BITS),
    .W  (W)
  ) u_finish (
    .clk    (clk),
    .rst    (rst),
    .en     (en[N-1]),
    .in_vld (vld[N-2]),
    .x_in   (cx[C]),
    .y_in   (cy[C]),
    .vld    (vld[N-1]),
    .bx     (bx),
    .by     (by),
    .sat    (clipped)
  );

  assign out_valid    = vld[N-1];
  assign body_x_speed = bx;
  assign body_y_speed = by;

  `VFR_ASSERT_NOW(a_ready_when_out_empty, !vld[N-1], in_ready)
  `VFR_ASSERT_NOW(a_stall_only_when_full, !in_ready, (&vld) && !out_ready)
  `VFR_ASSERT_NEXT(a_request_enters, in_valid && in_ready, vld[0])

endmodule

// ===== tb/sv/tb_velocity_frame_rotation.sv =====
`timescale 1ns / 100ps

module tb_velocity_frame_rotation;

  localparam int MICRO_ROTATIONS = 16;
  localparam int SPEED_BITS      = 16;
  localparam int ANGLE_BITS      = vfr_pkg::ANGLE_BITS;
  localparam int DRAIN_CYCLES    = MICRO_ROTATIONS + 12;

  typedef logic signed [SPEED_BITS-1:0] speed_t;
  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    speed_t body_x;
    speed_t body_y;
    logic   clip;
  } body_speed_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  angle_t heading_angle = '0;
  speed_t world_x_speed = '0;
  speed_t world_y_speed = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  speed_t body_x_speed;
  speed_t body_y_speed;
  logic   clipped;

  body_speed_t body_speed_q[$];
  int          error_count = 0;
  bit          no_idle = 1'b0;

  velocity_frame_rotation #(
    .MICRO_ROTATIONS(MICRO_ROTATIONS),
    .SPEED_BITS     (SPEED_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .heading_angle(heading_angle),
    .world_x_speed(world_x_speed),
    .world_y_speed(world_y_speed),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .body_x_speed (body_x_speed),
    .body_y_speed (body_y_speed),
    .clipped      (clipped)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("** velocity_frame_rotation: FAILED **");
    $finish;
  end

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0)
      return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic longint round_saturate(input longint acc, inout logic clip);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) << (SPEED_BITS - 1)) - 1;
    lo = -hi - 1;
    r  = (acc + (longint'(1) << (vfr_pkg::FRAC_BITS - 1))) >>> vfr_pkg::FRAC_BITS;
    if (r > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (r < lo) begin
      clip = 1'b1;
      return lo;
    end
    return r;
  endfunction

  function automatic body_speed_t rotate_to_body(input angle_t ang, input speed_t wx,
                                                 input speed_t wy);
    body_speed_t res;
    longint      a;
    longint      vx;
    longint      vy;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    logic        clip;
    a    = longint'(ang);
    vx   = longint'(wx);
    vy   = longint'(wy);
    clip = 1'b0;
    if (a >= 16384) begin
      a  = a - 32768;
      vx = -vx;
      vy = -vy;
    end else if (a < -16384) begin
      a  = a + 32768;
      vx = -vx;
      vy = -vy;
    end
    x = (vx * longint'(vfr_pkg::GAIN_Q30)) >>> (vfr_pkg::GAIN_SHIFT - vfr_pkg::FRAC_BITS);
    y = (vy * longint'(vfr_pkg::GAIN_Q30)) >>> (vfr_pkg::GAIN_SHIFT - vfr_pkg::FRAC_BITS);
    z = a * 65536;
    for (int i = 0; i < MICRO_ROTATIONS && i < vfr_pkg::TABLE_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(vfr_pkg::ATAN_TURNS[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(vfr_pkg::ATAN_TURNS[i]);
      end
    end
    res.body_x = speed_t'(round_saturate(x, clip));
    res.body_y = speed_t'(round_saturate(y, clip));
    res.clip   = clip;
    return res;
  endfunction

  task automatic send_request(input angle_t ang, input speed_t wx, input speed_t wy);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    heading_angle <= ang;
    world_x_speed <= wx;
    world_y_speed <= wy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    body_speed_q.push_back(rotate_to_body(ang, wx, wy));
  endtask

  task automatic check_field(input string name, input longint exp, input longint act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      error_count++;
    end
  endtask

  initial begin
    body_speed_t exp;
    int          gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (body_speed_q.size() == 0) begin
        $error("unexpected result: body_x_speed %0d body_y_speed %0d clipped %0d",
               body_x_speed, body_y_speed, clipped);
        error_count++;
      end else begin
        exp = body_speed_q.pop_front();
        check_field("body_x_speed", exp.body_x, body_x_speed);
        check_field("body_y_speed", exp.body_y, body_y_speed);
        check_field("clipped", exp.clip, clipped);
      end
    end
  end

  task automatic test_quadrant_folds();
    send_request(16'sd0, 16'sd1000, -16'sd500);
    send_request(16'sd8192, 16'sd1000, -16'sd500);
    send_request(-16'sd8192, 16'sd1000, -16'sd500);
    send_request(16'sd16383, 16'sd1000, -16'sd500);
    send_request(16'sd16384, 16'sd1000, -16'sd500);
    send_request(-16'sd16384, 16'sd1000, -16'sd500);
    send_request(-16'sd16385, 16'sd1000, -16'sd500);
    send_request(16'sd32767, 16'sd1000, -16'sd500);
    send_request(-16'sd32768, 16'sd1000, -16'sd500);
  endtask

  task automatic test_speed_extremes();
    send_request(16'sd0, 16'sd0, 16'sd0);
    send_request(16'sd0, 16'sd32767, 16'sd32767);
    send_request(16'sd0, -16'sd32768, -16'sd32768);
    send_request(-16'sd32768, -16'sd32768, 16'sd32767);
    send_request(16'sd16384, -16'sd32768, -16'sd32768);
    send_request(-16'sd16384, 16'sd32767, -16'sd32768);
    send_request(16'sd1, -16'sd1, 16'sd1);
  endtask

  task automatic test_saturation();
    send_request(16'sd8192, 16'sd32767, 16'sd32767);
    send_request(16'sd8192, -16'sd32768, -16'sd32768);
    send_request(-16'sd8192, 16'sd32767, -16'sd32768);
    send_request(16'sd24576, 16'sd32767, -16'sd32768);
    send_request(-16'sd24576, -16'sd30000, 16'sd30000);
  endtask

  task automatic test_random_headings(input int count);
    repeat (count)
      send_request(angle_t'($urandom_range(0, 65535)), speed_t'($urandom_range(0, 65535)),
                   speed_t'($urandom_range(0, 65535)));
  endtask

  task automatic test_fold_boundaries(input int count);
    int centers[4] = '{16384, -16384, -32768, 0};
    int ang;
    repeat (count) begin
      ang = centers[$urandom_range(0, 3)] + $urandom_range(0, 6) - 3;
      send_request(angle_t'(ang), speed_t'($urandom_range(0, 65535)),
                   speed_t'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_random_headings(count);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_quadrant_folds();
    test_speed_extremes();
    test_saturation();
    test_random_headings(200);
    test_fold_boundaries(70);
    test_back_to_back(90);
    test_random_headings(90);
    in_valid <= 1'b0;
    while (body_speed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** velocity_frame_rotation: PASSED **");
    else
      $display("** velocity_frame_rotation: FAILED **");
    $finish;
  end

endmodule
